// ----- rtl/hsv2bgr_pkg.sv -----
// Package for the HSV to BGR pixel converter: sector codes and channel constants.
// No dependencies; used by hsv2bgr_out_if and the top level.
package hsv2bgr_pkg;

  localparam int CHAN_W = 8;
  localparam int SECT_W = 4;

  typedef logic [SECT_W-1:0] sector_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // hexcone sectors; anything above SECT_5 is a full-turn hue (white)
  localparam sector_t SECT_0 = 4'd0;
  localparam sector_t SECT_1 = 4'd1;
  localparam sector_t SECT_2 = 4'd2;
  localparam sector_t SECT_3 = 4'd3;
  localparam sector_t SECT_4 = 4'd4;
  localparam sector_t SECT_5 = 4'd5;

  localparam chan_t CHAN_MAX = 8'd255;

endpackage

// ----- rtl/hsv2bgr_if.sv -----
// Valid/ready channel interfaces for the HSV to BGR converter.
// Depends on hsv2bgr_pkg for the channel type.
interface hsv2bgr_in_if #(
  parameter int FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2bgr_out_if
  import hsv2bgr_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t blue;
  chan_t green;
  chan_t red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

// ----- rtl/hsv_to_bgr_pixel_top.sv -----
// HSV to BGR pixel converter, four register stages, one request per clock while out_px.ready is high.
// Depends on hsv2bgr_pkg and the interfaces in hsv2bgr_if.sv.
//
//   channel  direction  handshake            payload
//   in_px    sink       valid/ready          hue, saturation, brightness (Q1.FRAC_BITS)
//   out_px   source     valid/ready          blue, green, red (8 bits each)
//
// An accepted request passes stages A, B, C and the output register; throughput is
// one request per clock while out_px.ready is high, as every stage then takes one.
// Each stage holds a valid bit and advances when the next stage is free or
// moving, so a stalled output fills the bubbles before in_px.ready drops.
// rst_n is synchronous, active low, and clears only the valid bits.
module hsv_to_bgr_pixel_top
  import hsv2bgr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hsv2bgr_in_if.sink           in_px,
  hsv2bgr_out_if.source        out_px
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // ---- input side: hue * 6, clamp s and v
  logic [W+2:0] h6;
  logic [W-1:0] s_cl, v_cl;

  assign h6   = ({3'b000, in_px.hue} << 2) + ({3'b000, in_px.hue} << 1);
  assign s_cl = (in_px.saturation > ONE) ? ONE : in_px.saturation;
  assign v_cl = (in_px.brightness > ONE) ? ONE : in_px.brightness;

  // ---- ready chain
  logic vld_a_r, vld_b_r, vld_c_r, out_vld_r;
  logic rdy_a, rdy_b, rdy_c, rdy_o;

  assign rdy_o = !out_vld_r || out_px.ready;
  assign rdy_c = !vld_c_r || rdy_o;
  assign rdy_b = !vld_b_r || rdy_c;
  assign rdy_a = !vld_a_r || rdy_b;
  assign in_px.ready = rdy_a;

  // ---- stage A: sector, fraction, clamped s and v
  sector_t              sector_a_r;
  logic [FRAC_BITS-1:0] f_a_r;
  logic [W-1:0]         s_a_r, v_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (rdy_a) begin
      vld_a_r <= in_px.valid;
    end
    if (rdy_a && in_px.valid) begin
      sector_a_r <= h6[W+2:FRAC_BITS];
      f_a_r      <= h6[FRAC_BITS-1:0];
      s_a_r      <= s_cl;
      v_a_r      <= v_cl;
    end
  end

  // ---- stage B: p, f*s, (1-f)*s
  logic [PW-1:0] p_prod, fs_prod, gs_prod;
  logic [W-1:0]  f_ext;

  assign f_ext   = {1'b0, f_a_r};
  assign p_prod  = {{W{1'b0}}, v_a_r} * {{W{1'b0}}, W'(ONE - s_a_r)};
  assign fs_prod = {{W{1'b0}}, f_ext} * {{W{1'b0}}, s_a_r};
  assign gs_prod = {{W{1'b0}}, W'(ONE - f_ext)} * {{W{1'b0}}, s_a_r};

  sector_t      sector_b_r;
  logic [W-1:0] p_b_r, fs_b_r, gs_b_r, v_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (rdy_b) begin
      vld_b_r <= vld_a_r;
    end
    if (rdy_b && vld_a_r) begin
      sector_b_r <= sector_a_r;
      p_b_r      <= p_prod[FRAC_BITS+W-1:FRAC_BITS];
      fs_b_r     <= fs_prod[FRAC_BITS+W-1:FRAC_BITS];
      gs_b_r     <= gs_prod[FRAC_BITS+W-1:FRAC_BITS];
      v_b_r      <= v_a_r;
    end
  end

  // ---- stage C: q and t
  logic [PW-1:0] q_prod, t_prod;

  assign q_prod = {{W{1'b0}}, v_b_r} * {{W{1'b0}}, W'(ONE - fs_b_r)};
  assign t_prod = {{W{1'b0}}, v_b_r} * {{W{1'b0}}, W'(ONE - gs_b_r)};

  sector_t      sector_c_r;
  logic [W-1:0] p_c_r, q_c_r, t_c_r, v_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (rdy_c) begin
      vld_c_r <= vld_b_r;
    end
    if (rdy_c && vld_b_r) begin
      sector_c_r <= sector_b_r;
      p_c_r      <= p_b_r;
      q_c_r      <= q_prod[FRAC_BITS+W-1:FRAC_BITS];
      t_c_r      <= t_prod[FRAC_BITS+W-1:FRAC_BITS];
      v_c_r      <= v_b_r;
    end
  end

  // ---- output stage: channel order, scale by 255
  logic [W-1:0]   r_lvl, g_lvl, b_lvl;
  logic [W+7:0]   r_sc, g_sc, b_sc;

  always_comb begin
    case (sector_c_r)
      SECT_0:  begin r_lvl = v_c_r; g_lvl = t_c_r; b_lvl = p_c_r; end
      SECT_1:  begin r_lvl = q_c_r; g_lvl = v_c_r; b_lvl = p_c_r; end
      SECT_2:  begin r_lvl = p_c_r; g_lvl = v_c_r; b_lvl = t_c_r; end
      SECT_3:  begin r_lvl = p_c_r; g_lvl = q_c_r; b_lvl = v_c_r; end
      SECT_4:  begin r_lvl = t_c_r; g_lvl = p_c_r; b_lvl = v_c_r; end
      SECT_5:  begin r_lvl = v_c_r; g_lvl = p_c_r; b_lvl = q_c_r; end
      default: begin r_lvl = ONE;   g_lvl = ONE;   b_lvl = ONE;   end
    endcase
  end

  // x * 255 = (x << 8) - x; levels never exceed ONE, so the byte never overflows
  assign r_sc = {r_lvl, 8'h00} - {8'h00, r_lvl};
  assign g_sc = {g_lvl, 8'h00} - {8'h00, g_lvl};
  assign b_sc = {b_lvl, 8'h00} - {8'h00, b_lvl};

  chan_t blue_r, green_r, red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy_o) begin
      out_vld_r <= vld_c_r;
    end
    if (rdy_o && vld_c_r) begin
      blue_r  <= b_sc[FRAC_BITS+7:FRAC_BITS];
      green_r <= g_sc[FRAC_BITS+7:FRAC_BITS];
      red_r   <= r_sc[FRAC_BITS+7:FRAC_BITS];
    end
  end

  assign out_px.valid = out_vld_r;
  assign out_px.blue  = blue_r;
  assign out_px.green = green_r;
  assign out_px.red   = red_r;

  // ---- checks
  a_back_pressure_full : assert property (@(posedge clk) disable iff (!rst_n)
    !rdy_a |-> (vld_a_r && vld_b_r && vld_c_r && out_vld_r))
    else $error("input stalled with a bubble in the pipeline");

  a_stage_c_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_c_r && rdy_o) |=> out_vld_r)
    else $error("request lost between stage C and output");

  a_white_sector : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_c_r && rdy_o && (sector_c_r > SECT_5)) |=>
      (blue_r == CHAN_MAX && green_r == CHAN_MAX && red_r == CHAN_MAX))
    else $error("full-turn hue did not give white");

  a_stage_a_to_b : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_a_r && rdy_b) |=> vld_b_r)
    else $error("request lost between stage A and B");

endmodule
